/* src/tgab_pkg.sv */
// shared constants and types for the triaxial gyro average and bias removal block
// no dependencies; compile first
package tgab_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int AVG_DEPTH   = 8;
	localparam int AVG_SHIFT   = 3;
	localparam int PTR_W       = 3;
	localparam int SUM_W       = SAMPLE_W + AVG_SHIFT;
	localparam int CALIB_ITEMS = 32;
	localparam int CALIB_SHIFT = 5;
	localparam int CALIB_CNT_W = 6;
	localparam int CSUM_W      = SAMPLE_W + CALIB_SHIFT;
	localparam int HOLD_W      = 16;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd1000;

	// per-axis control for one item
	typedef struct packed {
		logic step;        // item processed this cycle
		logic calib;       // item belongs to the calibration phase
		logic calib_done;  // last calibration item, latch bias
		logic capture;     // take last output as deviation
		logic trim;        // subtract deviation from result
	} axis_ctrl_t;

endpackage

/* src/tgab_if.sv */
// channel interfaces for raw samples and corrected rates
// depends on tgab_pkg
interface tgab_sample_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [tgab_pkg::SAMPLE_W-1:0] raw_x;
	logic signed [tgab_pkg::SAMPLE_W-1:0] raw_y;
	logic signed [tgab_pkg::SAMPLE_W-1:0] raw_z;

	modport source (output valid, raw_x, raw_y, raw_z, input ready);
	modport sink   (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface tgab_rate_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [tgab_pkg::SAMPLE_W-1:0] rate_x;
	logic signed [tgab_pkg::SAMPLE_W-1:0] rate_y;
	logic signed [tgab_pkg::SAMPLE_W-1:0] rate_z;
	logic                                  holding;

	modport source (output valid, rate_x, rate_y, rate_z, holding, input ready);
	modport sink   (input valid, rate_x, rate_y, rate_z, holding, output ready);
endinterface

/* src/tgab_axis.sv */
// one axis: sample ring, moving average, bias calibration, deviation trim
// depends on tgab_pkg
module tgab_axis (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tgab_pkg::axis_ctrl_t                  ctrl,
	input  logic [tgab_pkg::PTR_W-1:0]            ptr,
	input  logic signed [tgab_pkg::SAMPLE_W-1:0]  sample,
	output logic signed [tgab_pkg::SAMPLE_W-1:0]  rate
);

	logic signed [tgab_pkg::SAMPLE_W-1:0] ring_q [tgab_pkg::AVG_DEPTH];
	logic signed [tgab_pkg::CSUM_W-1:0]   csum_q;
	logic signed [tgab_pkg::SAMPLE_W-1:0] bias_q;
	logic signed [tgab_pkg::SAMPLE_W-1:0] dev_q;
	logic signed [tgab_pkg::SAMPLE_W-1:0] last_q;

	logic signed [tgab_pkg::SUM_W-1:0]    sum;
	logic signed [tgab_pkg::SAMPLE_W-1:0] avg;
	logic signed [tgab_pkg::CSUM_W-1:0]   csum_next;
	logic signed [tgab_pkg::SAMPLE_W-1:0] diff;
	logic signed [tgab_pkg::SAMPLE_W-1:0] dev_eff;

	// ring sum with the new sample already in its slot
	always_comb begin
		sum = '0;
		for (int i = 0; i < tgab_pkg::AVG_DEPTH; i++) begin
			if (tgab_pkg::PTR_W'(i) == ptr) begin
				sum = sum + tgab_pkg::SUM_W'(sample);
			end else begin
				sum = sum + tgab_pkg::SUM_W'(ring_q[i]);
			end
		end
	end

	// arithmetic shift gives the floor of the mean
	assign avg       = $signed(sum[tgab_pkg::SUM_W-1:tgab_pkg::AVG_SHIFT]);
	assign csum_next = csum_q + tgab_pkg::CSUM_W'(avg);
	assign diff      = avg - bias_q;
	assign dev_eff   = ctrl.capture ? last_q : dev_q;
	assign rate      = ctrl.trim ? (diff - dev_eff) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tgab_pkg::AVG_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			csum_q <= '0;
			bias_q <= '0;
			dev_q  <= '0;
			last_q <= '0;
		end else if (ctrl.step) begin
			ring_q[ptr] <= sample;
			if (ctrl.calib) begin
				csum_q <= csum_next;
				if (ctrl.calib_done) begin
					bias_q <= $signed(csum_next[tgab_pkg::CSUM_W-1:tgab_pkg::CALIB_SHIFT]);
				end
			end else begin
				if (ctrl.capture) begin
					dev_q <= last_q;
				end
				last_q <= rate;
			end
		end
	end

endmodule

/* src/triaxial_gyro_average_bias_remove_unit.sv */
// top level of the triaxial gyro average and bias removal block
// depends on tgab_pkg, tgab_if (channel interfaces) and tgab_axis
//
// channel    | direction | contents
// -----------+-----------+-------------------------------------------
// samples    | sink      | raw_x, raw_y, raw_z (signed 16 bit)
// rates      | source    | rate_x, rate_y, rate_z (signed 16), holding
// cfg_we/... | write     | hold_items (16 bit, reset 1000)
//
// one sample transaction per cycle sustained while rates does not stall; two
// register stages (input register, then result register); rates.valid rises
// once a sample has passed the input register into a free result register
// the first 32 samples only calibrate the bias and give no rate transaction
// a stall on rates holds the result register; samples stays ready while the
// result register is free or being drained, and calibration samples never stall
// arst_n clears the rings, the bias, the deviation and all counters at once
module triaxial_gyro_average_bias_remove_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	tgab_sample_if.sink                       samples,
	tgab_rate_if.source                       rates,
	input  logic                              cfg_we,
	input  logic [tgab_pkg::HOLD_W-1:0]       cfg_wdata
);

	// input stage
	logic                                 valid_s1;
	logic signed [tgab_pkg::SAMPLE_W-1:0] raw_x_s1;
	logic signed [tgab_pkg::SAMPLE_W-1:0] raw_y_s1;
	logic signed [tgab_pkg::SAMPLE_W-1:0] raw_z_s1;

	// control state
	logic [tgab_pkg::PTR_W-1:0]       ptr_q;
	logic [tgab_pkg::CALIB_CNT_W-1:0] calib_cnt_q;
	logic [tgab_pkg::HOLD_W-1:0]      hold_cnt_q;
	logic [tgab_pkg::HOLD_W-1:0]      hold_items_q;

	// result register
	logic                                 out_valid_q;
	logic signed [tgab_pkg::SAMPLE_W-1:0] rate_x_q;
	logic signed [tgab_pkg::SAMPLE_W-1:0] rate_y_q;
	logic signed [tgab_pkg::SAMPLE_W-1:0] rate_z_q;
	logic                                 holding_q;

	logic                                 calib;
	logic                                 out_free;
	logic                                 s1_fire;
	logic                                 in_ready;
	logic                                 capture;
	logic [tgab_pkg::HOLD_W-1:0]          hold_next;
	logic                                 hold;
	tgab_pkg::axis_ctrl_t                 ctrl;
	logic signed [tgab_pkg::SAMPLE_W-1:0] rate_x_d;
	logic signed [tgab_pkg::SAMPLE_W-1:0] rate_y_d;
	logic signed [tgab_pkg::SAMPLE_W-1:0] rate_z_d;

	// calibration runs until the counter reaches the item count
	assign calib    = (calib_cnt_q != tgab_pkg::CALIB_CNT_W'(tgab_pkg::CALIB_ITEMS));
	assign out_free = !out_valid_q || rates.ready;
	// calibration items produce nothing, so they never wait on the output
	assign s1_fire  = valid_s1 && (calib || out_free);
	assign in_ready = !valid_s1 || s1_fire;
	assign samples.ready = in_ready;

	// hold window: count first, then compare with the new count
	assign capture   = !calib && (hold_cnt_q < hold_items_q);
	assign hold_next = capture ? (hold_cnt_q + tgab_pkg::HOLD_W'(1)) : hold_cnt_q;
	assign hold      = (hold_next < hold_items_q);

	always_comb begin
		ctrl            = '0;
		ctrl.step       = s1_fire;
		ctrl.calib      = calib;
		ctrl.calib_done = calib
			&& (calib_cnt_q == tgab_pkg::CALIB_CNT_W'(tgab_pkg::CALIB_ITEMS - 1));
		ctrl.capture    = capture;
		ctrl.trim       = !hold;
	end

	tgab_axis u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.ptr    (ptr_q),
		.sample (raw_x_s1),
		.rate   (rate_x_d)
	);

	tgab_axis u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.ptr    (ptr_q),
		.sample (raw_y_s1),
		.rate   (rate_y_d)
	);

	tgab_axis u_axis_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.ptr    (ptr_q),
		.sample (raw_z_s1),
		.rate   (rate_z_d)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && samples.valid) begin
			raw_x_s1 <= samples.raw_x;
			raw_y_s1 <= samples.raw_y;
			raw_z_s1 <= samples.raw_z;
		end
	end

	// configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_items_q <= tgab_pkg::HOLD_RESET;
			ptr_q        <= '0;
			calib_cnt_q  <= '0;
			hold_cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				hold_items_q <= cfg_wdata;
			end
			if (s1_fire) begin
				// ring depth is a power of two, pointer wraps by itself
				ptr_q <= ptr_q + tgab_pkg::PTR_W'(1);
				if (calib) begin
					calib_cnt_q <= calib_cnt_q + tgab_pkg::CALIB_CNT_W'(1);
				end
				hold_cnt_q <= hold_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && !calib) begin
			out_valid_q <= 1'b1;
		end else if (rates.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && !calib) begin
			rate_x_q  <= rate_x_d;
			rate_y_q  <= rate_y_d;
			rate_z_q  <= rate_z_d;
			holding_q <= hold;
		end
	end

	assign rates.valid   = out_valid_q;
	assign rates.rate_x  = rate_x_q;
	assign rates.rate_y  = rate_y_q;
	assign rates.rate_z  = rate_z_q;
	assign rates.holding = holding_q;

endmodule

/* src/tgab_checker.sv */
// port-level assertions for the triaxial gyro average and bias removal block
// depends on tgab_pkg; bound to the top level below
module tgab_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [tgab_pkg::SAMPLE_W-1:0] rate_x,
	input logic signed [tgab_pkg::SAMPLE_W-1:0] rate_y,
	input logic signed [tgab_pkg::SAMPLE_W-1:0] rate_z,
	input logic                                 holding
);

	logic                             in_acc;
	logic                             out_acc;
	logic                             post_in;
	logic [tgab_pkg::CALIB_CNT_W-1:0] seen_q;
	logic [2:0]                       pend_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign post_in = in_acc && (seen_q == tgab_pkg::CALIB_CNT_W'(tgab_pkg::CALIB_ITEMS));

	// accepted samples up to the calibration length, then items awaiting delivery
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			pend_q <= '0;
		end else begin
			if (in_acc && !post_in) begin
				seen_q <= seen_q + tgab_pkg::CALIB_CNT_W'(1);
			end
			pend_q <= pend_q + 3'(post_in) - 3'(out_acc);
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rate_x) && $stable(rate_y)
			&& $stable(rate_z) && $stable(holding))
		else $error("rate transaction changed while stalled");

	a_no_early_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_q == tgab_pkg::CALIB_CNT_W'(tgab_pkg::CALIB_ITEMS))
		else $error("rate transaction during calibration");

	a_rate_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("rate transaction without a matching sample");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd2)
		else $error("more samples in flight than pipeline stages");

endmodule

bind triaxial_gyro_average_bias_remove_unit tgab_checker u_tgab_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (rates.valid),
	.out_ready (rates.ready),
	.rate_x    (rates.rate_x),
	.rate_y    (rates.rate_y),
	.rate_z    (rates.rate_z),
	.holding   (rates.holding)
);
